// ===== design/tickclk_pkg.sv =====
package tickclk_pkg;

   localparam int DEF_NUM_SLOTS   = 8;
   localparam int DEF_TIMER_WIDTH = 16;

   localparam int ACTION_W = 3;
   localparam int SLOT_W   = 3;
   localparam int VALUE_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_ALLOC   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_LOAD    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_READ    = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_WRITE   = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASES    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_CMP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_CMP  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UPS       = 2'd3;

   localparam logic [3:0] RST_PHASES    = 4'd3;
   localparam logic [7:0] RST_SHORT_CMP = 8'd207;
   localparam logic [7:0] RST_LONG_CMP  = 8'd208;
   localparam logic [7:0] RST_UPS       = 8'd100;

   localparam logic [3:0] MAX_PHASES    = 4'd8;
   localparam logic [6:0] HUNDREDTHS_TOP = 7'd99;
   localparam logic [5:0] MINUTE_TOP    = 6'd59;
   localparam logic [4:0] HOUR_TOP      = 5'd23;

   typedef struct packed {
      logic [ACTION_W-1:0] act;
      logic                upd;
      logic [SLOT_W-1:0]   slot;
      logic                found;
      logic                ok;
   } ctl_type;

   typedef struct packed {
      logic               ok;
      logic [SLOT_W-1:0]  slot_index;
      logic [VALUE_W-1:0] slot_value;
      logic [7:0]         next_compare;
      logic               update_done;
      logic [6:0]         hundredths;
      logic [5:0]         clock_seconds;
      logic [5:0]         clock_minutes;
      logic [4:0]         clock_hours;
      logic [15:0]        elapsed_seconds;
      logic [15:0]        free_count_a;
      logic [15:0]        free_count_b;
   } result_type;

endpackage

// ===== design/tickclk_cell.sv =====
module tickclk_cell import tickclk_pkg::*; #(
   parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
   parameter int TIMER_WIDTH = DEF_TIMER_WIDTH,
   parameter int CELL_INDEX  = 0,
   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid_in,
   input  ctl_type                ctl_in,
   input  logic [VALUE_W-1:0]     ld_value_in,
   input  logic [TIMER_WIDTH-1:0] echo_in,
   input  logic [TIMER_WIDTH-1:0] grant_val_in,
   input  logic [IDX_W-1:0]       grant_idx_in,
   output logic                   valid_out,
   output ctl_type                ctl_out,
   output logic [VALUE_W-1:0]     ld_value_out,
   output logic [TIMER_WIDTH-1:0] echo_out,
   output logic [TIMER_WIDTH-1:0] grant_val_out,
   output logic [IDX_W-1:0]       grant_idx_out
);

   localparam bit                REACHABLE = CELL_INDEX < (1 << SLOT_W);
   localparam logic [SLOT_W-1:0] MY_SLOT   = SLOT_W'(CELL_INDEX);
   localparam logic [IDX_W-1:0]  MY_IDX    = IDX_W'(CELL_INDEX);

   logic [TIMER_WIDTH-1:0] value_ff, value_in;
   logic                   active_ff, active_in;
   logic                   valid_ff;
   ctl_type                ctl_ff, ctl_in_next;
   logic [VALUE_W-1:0]     ld_value_ff;
   logic [TIMER_WIDTH-1:0] echo_ff, echo_next;
   logic [TIMER_WIDTH-1:0] grant_val_ff, grant_val_next;
   logic [IDX_W-1:0]       grant_idx_ff, grant_idx_next;
   logic                   hit;

   always_comb begin
      hit            = REACHABLE && (ctl_in.slot == MY_SLOT);
      value_in       = value_ff;
      active_in      = active_ff;
      ctl_in_next    = ctl_in;
      grant_val_next = grant_val_in;
      grant_idx_next = grant_idx_in;
      echo_next      = echo_in;
      if (valid_in) begin
         case (ctl_in.act)
            ACT_TICK: begin
               if (ctl_in.upd && active_ff && (value_ff != '0)) begin
                  value_in = value_ff - TIMER_WIDTH'(1);
               end
            end
            ACT_ALLOC: begin
               if (!ctl_in.found && !active_ff) begin
                  active_in         = 1'b1;
                  ctl_in_next.found = 1'b1;
                  grant_idx_next    = MY_IDX;
                  grant_val_next    = value_ff;
               end
            end
            ACT_RELEASE: begin
               if (hit && active_ff) begin
                  active_in      = 1'b0;
                  ctl_in_next.ok = 1'b1;
               end
            end
            ACT_LOAD: begin
               if (hit) begin
                  value_in = TIMER_WIDTH'(ld_value_in);
               end
            end
            default: begin
            end
         endcase
         if (hit) begin
            echo_next = value_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff  <= '0;
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         value_ff  <= value_in;
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
      ctl_ff       <= ctl_in_next;
      ld_value_ff  <= ld_value_in;
      echo_ff      <= echo_next;
      grant_val_ff <= grant_val_next;
      grant_idx_ff <= grant_idx_next;
   end

   assign valid_out     = valid_ff;
   assign ctl_out       = ctl_ff;
   assign ld_value_out  = ld_value_ff;
   assign echo_out      = echo_ff;
   assign grant_val_out = grant_val_ff;
   assign grant_idx_out = grant_idx_ff;

endmodule

// ===== design/tick_clock_with_countdown_timers_core.sv =====
// A taken request word passes through the slot cells' registers in turn, then into the
// output register, which presents its response word. Each word walks the row of slot
// cells one cell per cycle; only one word is in the row at a time. A stalled response
// holds the output register while the next word is taken; a second finished word is
// parked in a holding stage, which stalls the request side.
// Synchronous reset: time, counters, phase and slots clear; registers go to 3/207/208/100.
module tick_clock_with_countdown_timers_core import tickclk_pkg::*; #(
   parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
   parameter int TIMER_WIDTH = DEF_TIMER_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [SLOT_W-1:0]     req_slot,
   input  logic [VALUE_W-1:0]    req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_ok,
   output logic [SLOT_W-1:0]     rsp_slot_index,
   output logic [VALUE_W-1:0]    rsp_slot_value,
   output logic [7:0]            rsp_next_compare,
   output logic                  rsp_update_done,
   output logic [6:0]            rsp_hundredths,
   output logic [5:0]            rsp_clock_seconds,
   output logic [5:0]            rsp_clock_minutes,
   output logic [4:0]            rsp_clock_hours,
   output logic [15:0]           rsp_elapsed_seconds,
   output logic [15:0]           rsp_free_count_a,
   output logic [15:0]           rsp_free_count_b,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   logic [3:0]  phases_ff;
   logic [7:0]  short_cmp_ff, long_cmp_ff, ups_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  sub_ff, sub_in;
   logic [6:0]  hund_ff, hund_in;
   logic [5:0]  secs_ff, secs_in, mins_ff, mins_in;
   logic [4:0]  hours_ff, hours_in;
   logic [15:0] elapsed_ff, elapsed_in, count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic [7:0]  cmp_ff, cmp_in;
   logic        busy_ff, park_vld_ff, rsp_vld_ff;
   result_type  park_ff, rsp_ff, res;

   logic        req_take, rsp_free, is_final, do_upd;
   logic [2:0]  eff_m1;
   logic [7:0]  sub_inc;
   ctl_type     ctl_head;

   logic [NUM_SLOTS:0]     vld_c;
   ctl_type                ctl_c      [0:NUM_SLOTS];
   logic [VALUE_W-1:0]     ldv_c      [0:NUM_SLOTS];
   logic [TIMER_WIDTH-1:0] echo_c     [0:NUM_SLOTS];
   logic [TIMER_WIDTH-1:0] grant_v_c  [0:NUM_SLOTS];
   logic [IDX_W-1:0]       grant_i_c  [0:NUM_SLOTS];

   assign req_stall = busy_ff || park_vld_ff;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_vld_ff || !rsp_stall;

   always_comb begin
      if (phases_ff == 4'd0) begin
         eff_m1 = 3'd0;
      end else if (phases_ff > MAX_PHASES) begin
         eff_m1 = 3'(MAX_PHASES - 4'd1);
      end else begin
         eff_m1 = 3'(phases_ff - 4'd1);
      end
      is_final = phase_ff >= eff_m1;
      do_upd   = (req_action == ACT_TICK) && is_final;
      cmp_in   = is_final ? long_cmp_ff : short_cmp_ff;

      phase_in   = phase_ff;
      sub_in     = sub_ff;
      hund_in    = hund_ff;
      secs_in    = secs_ff;
      mins_in    = mins_ff;
      hours_in   = hours_ff;
      elapsed_in = elapsed_ff;
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      sub_inc    = sub_ff + 8'd1;

      case (req_action)
         ACT_TICK: begin
            if (is_final) begin
               phase_in   = 3'd0;
               count_a_in = count_a_ff + 16'd1;
               count_b_in = count_b_ff + 16'd1;
               hund_in    = (hund_ff >= HUNDREDTHS_TOP) ? 7'd0 : hund_ff + 7'd1;
               sub_in     = sub_inc;
               if (sub_inc == ups_ff) begin
                  sub_in     = 8'd0;
                  elapsed_in = elapsed_ff + 16'd1;
                  if (secs_ff >= MINUTE_TOP) begin
                     secs_in = 6'd0;
                     if (mins_ff >= MINUTE_TOP) begin
                        mins_in  = 6'd0;
                        hours_in = (hours_ff >= HOUR_TOP) ? 5'd0 : hours_ff + 5'd1;
                     end else begin
                        mins_in = mins_ff + 6'd1;
                     end
                  end else begin
                     secs_in = secs_ff + 6'd1;
                  end
               end
            end else begin
               phase_in = phase_ff + 3'd1;
            end
         end
         ACT_WRITE: begin
            if (req_slot == SLOT_W'(0)) begin
               count_a_in = req_value;
            end else if (req_slot == SLOT_W'(1)) begin
               count_b_in = req_value;
            end
         end
         default: begin
         end
      endcase

      ctl_head.act   = req_action;
      ctl_head.upd   = do_upd;
      ctl_head.slot  = req_slot;
      ctl_head.found = 1'b0;
      ctl_head.ok    = 1'b0;
   end

   assign vld_c[0]     = req_take;
   assign ctl_c[0]     = ctl_head;
   assign ldv_c[0]     = req_value;
   assign echo_c[0]    = '0;
   assign grant_v_c[0] = '0;
   assign grant_i_c[0] = '0;

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      tickclk_cell #(
         .NUM_SLOTS   (NUM_SLOTS),
         .TIMER_WIDTH (TIMER_WIDTH),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .valid_in      (vld_c[i]),
         .ctl_in        (ctl_c[i]),
         .ld_value_in   (ldv_c[i]),
         .echo_in       (echo_c[i]),
         .grant_val_in  (grant_v_c[i]),
         .grant_idx_in  (grant_i_c[i]),
         .valid_out     (vld_c[i+1]),
         .ctl_out       (ctl_c[i+1]),
         .ld_value_out  (ldv_c[i+1]),
         .echo_out      (echo_c[i+1]),
         .grant_val_out (grant_v_c[i+1]),
         .grant_idx_out (grant_i_c[i+1])
      );
   end

   always_comb begin
      res.ok              = ctl_c[NUM_SLOTS].ok;
      res.slot_index      = ctl_c[NUM_SLOTS].slot;
      res.slot_value      = VALUE_W'(echo_c[NUM_SLOTS]);
      if (ctl_c[NUM_SLOTS].act == ACT_ALLOC) begin
         res.ok = ctl_c[NUM_SLOTS].found;
         if (ctl_c[NUM_SLOTS].found) begin
            res.slot_index = SLOT_W'(grant_i_c[NUM_SLOTS]);
            res.slot_value = VALUE_W'(grant_v_c[NUM_SLOTS]);
         end
      end
      res.next_compare    = cmp_ff;
      res.update_done     = ctl_c[NUM_SLOTS].upd;
      res.hundredths      = hund_ff;
      res.clock_seconds   = secs_ff;
      res.clock_minutes   = mins_ff;
      res.clock_hours     = hours_ff;
      res.elapsed_seconds = elapsed_ff;
      res.free_count_a    = count_a_ff;
      res.free_count_b    = count_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phases_ff    <= RST_PHASES;
         short_cmp_ff <= RST_SHORT_CMP;
         long_cmp_ff  <= RST_LONG_CMP;
         ups_ff       <= RST_UPS;
         phase_ff     <= '0;
         sub_ff       <= '0;
         hund_ff      <= '0;
         secs_ff      <= '0;
         mins_ff      <= '0;
         hours_ff     <= '0;
         elapsed_ff   <= '0;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         busy_ff      <= 1'b0;
         park_vld_ff  <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PHASES:    phases_ff    <= 4'(csr_data);
               CSR_SHORT_CMP: short_cmp_ff <= csr_data;
               CSR_LONG_CMP:  long_cmp_ff  <= csr_data;
               CSR_UPS:       ups_ff       <= csr_data;
               default: begin
               end
            endcase
         end
         if (req_take) begin
            phase_ff   <= phase_in;
            sub_ff     <= sub_in;
            hund_ff    <= hund_in;
            secs_ff    <= secs_in;
            mins_ff    <= mins_in;
            hours_ff   <= hours_in;
            elapsed_ff <= elapsed_in;
            count_a_ff <= count_a_in;
            count_b_ff <= count_b_in;
            busy_ff    <= 1'b1;
         end else if (vld_c[NUM_SLOTS]) begin
            busy_ff <= 1'b0;
         end
         // drain the holding stage first, then the row's finished word
         if (park_vld_ff && rsp_free) begin
            rsp_vld_ff  <= 1'b1;
            park_vld_ff <= 1'b0;
         end else if (vld_c[NUM_SLOTS]) begin
            if (rsp_free) begin
               rsp_vld_ff <= 1'b1;
            end else begin
               park_vld_ff <= 1'b1;
            end
         end else if (rsp_free) begin
            rsp_vld_ff <= 1'b0;
         end
      end
      if (req_take) begin
         cmp_ff <= cmp_in;
      end
      if (park_vld_ff && rsp_free) begin
         rsp_ff <= park_ff;
      end else if (vld_c[NUM_SLOTS]) begin
         if (rsp_free) begin
            rsp_ff <= res;
         end else begin
            park_ff <= res;
         end
      end
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_ok              = rsp_ff.ok;
   assign rsp_slot_index      = rsp_ff.slot_index;
   assign rsp_slot_value      = rsp_ff.slot_value;
   assign rsp_next_compare    = rsp_ff.next_compare;
   assign rsp_update_done     = rsp_ff.update_done;
   assign rsp_hundredths      = rsp_ff.hundredths;
   assign rsp_clock_seconds   = rsp_ff.clock_seconds;
   assign rsp_clock_minutes   = rsp_ff.clock_minutes;
   assign rsp_clock_hours     = rsp_ff.clock_hours;
   assign rsp_elapsed_seconds = rsp_ff.elapsed_seconds;
   assign rsp_free_count_a    = rsp_ff.free_count_a;
   assign rsp_free_count_b    = rsp_ff.free_count_b;

   a_one_word_in_row: assert property (@(posedge clock) disable iff (reset)
      $onehot0(vld_c))
      else $error("more than one word in the slot row");

   a_park_only_idle: assert property (@(posedge clock) disable iff (reset)
      park_vld_ff |-> (!busy_ff && rsp_vld_ff))
      else $error("holding stage full while row busy or response empty");

   a_row_end_busy: assert property (@(posedge clock) disable iff (reset)
      vld_c[NUM_SLOTS] |-> busy_ff)
      else $error("row finished a word that was never taken");

   a_clock_range: assert property (@(posedge clock) disable iff (reset)
      (hund_ff <= HUNDREDTHS_TOP) && (secs_ff <= MINUTE_TOP) &&
      (mins_ff <= MINUTE_TOP) && (hours_ff <= HOUR_TOP))
      else $error("time of day out of range");

endmodule

// ===== tb/tick_clock_with_countdown_timers_core_tb.sv =====
module tick_clock_with_countdown_timers_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tickclk_pkg::*;

   localparam int SLOTS = DEF_NUM_SLOTS;
   localparam int IDLE_LIMIT = 5000;
   localparam int NUM_SETTINGS = 8;
   localparam int WORDS_PER_SETTING = 130;

   localparam logic [ACTION_W-1:0] ACT_RSVD6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_RSVD7 = 3'd7;
   localparam logic [SLOT_W-1:0] SEL_COUNT_A = 3'd0;
   localparam logic [SLOT_W-1:0] SEL_COUNT_B = 3'd1;

   class rtc_tracker;
      logic [3:0]         phases_reg;
      logic [7:0]         short_top;
      logic [7:0]         long_top;
      logic [7:0]         ups_reg;
      logic [2:0]         phase;
      logic [7:0]         sub_second;
      logic [6:0]         hundredths;
      logic [5:0]         secs;
      logic [5:0]         mins;
      logic [4:0]         hours;
      logic [15:0]        elapsed;
      logic [15:0]        count_a;
      logic [15:0]        count_b;
      logic [VALUE_W-1:0] slot_val [SLOTS];
      bit                 slot_busy [SLOTS];
      result_type         due_status [$];
      int                 mismatches;
      int                 words_seen;

      function new();
         phases_reg = RST_PHASES;
         short_top  = RST_SHORT_CMP;
         long_top   = RST_LONG_CMP;
         ups_reg    = RST_UPS;
         phase      = '0;
         sub_second = '0;
         hundredths = '0;
         secs       = '0;
         mins       = '0;
         hours      = '0;
         elapsed    = '0;
         count_a    = '0;
         count_b    = '0;
         foreach (slot_val[i]) begin
            slot_val[i]  = '0;
            slot_busy[i] = 1'b0;
         end
         mismatches = 0;
         words_seen = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_PHASES:    phases_reg = data[3:0];
            CSR_SHORT_CMP: short_top  = data;
            CSR_LONG_CMP:  long_top   = data;
            CSR_UPS:       ups_reg    = data;
            default: ;
         endcase
      endfunction

      function int phase_span();
         if (phases_reg == 4'd0) return 1;
         if (phases_reg > MAX_PHASES) return int'(MAX_PHASES);
         return int'(phases_reg);
      endfunction

      function bit last_phase();
         return int'(phase) >= phase_span() - 1;
      endfunction

      function void run_update();
         count_a++;
         count_b++;
         foreach (slot_val[i])
            if (slot_busy[i] && slot_val[i] != '0) slot_val[i]--;
         hundredths = (hundredths == HUNDREDTHS_TOP) ? 7'd0 : hundredths + 7'd1;
         sub_second++;
         if (sub_second == ups_reg) begin
            sub_second = '0;
            elapsed++;
            if (secs == MINUTE_TOP) begin
               secs = '0;
               if (mins == MINUTE_TOP) begin
                  mins  = '0;
                  hours = (hours == HOUR_TOP) ? 5'd0 : hours + 5'd1;
               end else begin
                  mins++;
               end
            end else begin
               secs++;
            end
         end
      endfunction

      function void note_request(logic [ACTION_W-1:0] act, logic [SLOT_W-1:0] sel,
                                 logic [VALUE_W-1:0] val);
         result_type r;
         bit         granted;
         r = '0;
         r.slot_index = sel;
         granted = 1'b0;
         case (act)
            ACT_TICK: begin
               r.next_compare = last_phase() ? long_top : short_top;
               if (last_phase()) begin
                  phase = '0;
                  r.update_done = 1'b1;
                  run_update();
               end else begin
                  phase = phase + 3'd1;
               end
            end
            ACT_ALLOC: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (!granted && !slot_busy[i]) begin
                     slot_busy[i] = 1'b1;
                     granted      = 1'b1;
                     r.ok         = 1'b1;
                     r.slot_index = i[SLOT_W-1:0];
                  end
               end
            end
            ACT_RELEASE: begin
               if (int'(sel) < SLOTS && slot_busy[sel]) begin
                  slot_busy[sel] = 1'b0;
                  r.ok = 1'b1;
               end
            end
            ACT_LOAD: begin
               if (int'(sel) < SLOTS) slot_val[sel] = val;
            end
            ACT_WRITE: begin
               if (sel == SEL_COUNT_A) count_a = val;
               else if (sel == SEL_COUNT_B) count_b = val;
            end
            default: ;
         endcase
         if (act != ACT_TICK) r.next_compare = last_phase() ? long_top : short_top;
         r.slot_value      = (int'(r.slot_index) < SLOTS) ? slot_val[r.slot_index] : '0;
         r.hundredths      = hundredths;
         r.clock_seconds   = secs;
         r.clock_minutes   = mins;
         r.clock_hours     = hours;
         r.elapsed_seconds = elapsed;
         r.free_count_a    = count_a;
         r.free_count_b    = count_b;
         due_status.push_back(r);
      endfunction

      function int pending();
         return due_status.size();
      endfunction

      task report(string what);
         if (mismatches < 40) $display("MISMATCH word %0d: %s", words_seen, what);
         mismatches++;
      endtask

      task check_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
      endtask

      task check_response(result_type got);
         result_type want;
         if (due_status.size() == 0) begin
            report("response with nothing outstanding");
         end else begin
            want = due_status.pop_front();
            check_field("ok", 16'(got.ok), 16'(want.ok));
            check_field("slot_index", 16'(got.slot_index), 16'(want.slot_index));
            check_field("slot_value", got.slot_value, want.slot_value);
            check_field("next_compare", 16'(got.next_compare), 16'(want.next_compare));
            check_field("update_done", 16'(got.update_done), 16'(want.update_done));
            check_field("hundredths", 16'(got.hundredths), 16'(want.hundredths));
            check_field("clock_seconds", 16'(got.clock_seconds), 16'(want.clock_seconds));
            check_field("clock_minutes", 16'(got.clock_minutes), 16'(want.clock_minutes));
            check_field("clock_hours", 16'(got.clock_hours), 16'(want.clock_hours));
            check_field("elapsed_seconds", got.elapsed_seconds, want.elapsed_seconds);
            check_field("free_count_a", got.free_count_a, want.free_count_a);
            check_field("free_count_b", got.free_count_b, want.free_count_b);
         end
         words_seen++;
      endtask
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_valid  = 1'b0;
   logic                  req_stall;
   logic [ACTION_W-1:0]   req_action = '0;
   logic [SLOT_W-1:0]     req_slot   = '0;
   logic [VALUE_W-1:0]    req_value  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall  = 1'b0;
   logic                  rsp_ok;
   logic [SLOT_W-1:0]     rsp_slot_index;
   logic [VALUE_W-1:0]    rsp_slot_value;
   logic [7:0]            rsp_next_compare;
   logic                  rsp_update_done;
   logic [6:0]            rsp_hundredths;
   logic [5:0]            rsp_clock_seconds;
   logic [5:0]            rsp_clock_minutes;
   logic [4:0]            rsp_clock_hours;
   logic [15:0]           rsp_elapsed_seconds;
   logic [15:0]           rsp_free_count_a;
   logic [15:0]           rsp_free_count_b;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   bit         steady_flow = 1'b0;
   rtc_tracker rtc;

   logic [3:0] set_phases [NUM_SETTINGS] = '{4'd1, 4'd15, 4'd0, 4'd8, 4'd2, 4'd1, 4'd5, 4'd3};
   logic [7:0] set_short  [NUM_SETTINGS] = '{8'd0, 8'd255, 8'd17, 8'd100, 8'd128, 8'd255,
                                             8'd85, 8'd207};
   logic [7:0] set_long   [NUM_SETTINGS] = '{8'd255, 8'd0, 8'd200, 8'd101, 8'd127, 8'd255,
                                             8'd170, 8'd208};
   logic [7:0] set_ups    [NUM_SETTINGS] = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd1, 8'd1, 8'd50,
                                             8'd100};

   tick_clock_with_countdown_timers_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_slot            (req_slot),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_ok              (rsp_ok),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_slot_value      (rsp_slot_value),
      .rsp_next_compare    (rsp_next_compare),
      .rsp_update_done     (rsp_update_done),
      .rsp_hundredths      (rsp_hundredths),
      .rsp_clock_seconds   (rsp_clock_seconds),
      .rsp_clock_minutes   (rsp_clock_minutes),
      .rsp_clock_hours     (rsp_clock_hours),
      .rsp_elapsed_seconds (rsp_elapsed_seconds),
      .rsp_free_count_a    (rsp_free_count_a),
      .rsp_free_count_b    (rsp_free_count_b),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int hold_len();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
   endfunction

   task automatic send(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] sel,
                       input logic [VALUE_W-1:0] val);
      int gap;
      gap = (!steady_flow && $urandom_range(0, 99) < 35) ? hold_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_slot   <= sel;
      req_value  <= val;
      do @(posedge clock); while (req_stall);
      rtc.note_request(act, sel, val);
   endtask

   task automatic send_random();
      int                  pick;
      logic [ACTION_W-1:0] act;
      logic [SLOT_W-1:0]   sel;
      logic [VALUE_W-1:0]  val;
      pick = $urandom_range(0, 99);
      sel  = SLOT_W'($urandom_range(0, 7));
      val  = VALUE_W'($urandom_range(0, 65535));
      if (pick < 45) begin
         act = ACT_TICK;
      end else if (pick < 55) begin
         act = ACT_ALLOC;
      end else if (pick < 65) begin
         act = ACT_RELEASE;
      end else if (pick < 80) begin
         act = ACT_LOAD;
         if ($urandom_range(0, 9) < 6) val = VALUE_W'($urandom_range(0, 6));
      end else if (pick < 90) begin
         act = ACT_READ;
      end else if (pick < 96) begin
         act = ACT_WRITE;
         if ($urandom_range(0, 9) < 7) sel = SLOT_W'($urandom_range(0, 1));
         if ($urandom_range(0, 1) == 1) val = VALUE_W'(16'hFFFE + $urandom_range(0, 1));
      end else begin
         act = ($urandom_range(0, 1) == 1) ? ACT_RSVD6 : ACT_RSVD7;
      end
      send(act, sel, val);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      rtc.write_reg(idx, data);
   endtask

   task automatic apply_setting(input int n);
      logic [3:0] junk_hi;
      junk_hi = 4'($urandom_range(0, 15));
      csr_write(CSR_PHASES, {junk_hi, set_phases[n]});
      csr_write(CSR_SHORT_CMP, set_short[n]);
      csr_write(CSR_LONG_CMP, set_long[n]);
      csr_write(CSR_UPS, set_ups[n]);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (rtc.pending() != 0) @(posedge clock);
   endtask

   initial begin : rsp_side
      result_type got;
      int         stall_run;
      stall_run = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.ok              = rsp_ok;
            got.slot_index      = rsp_slot_index;
            got.slot_value      = rsp_slot_value;
            got.next_compare    = rsp_next_compare;
            got.update_done     = rsp_update_done;
            got.hundredths      = rsp_hundredths;
            got.clock_seconds   = rsp_clock_seconds;
            got.clock_minutes   = rsp_clock_minutes;
            got.clock_hours     = rsp_clock_hours;
            got.elapsed_seconds = rsp_elapsed_seconds;
            got.free_count_a    = rsp_free_count_a;
            got.free_count_b    = rsp_free_count_b;
            rtc.check_response(got);
         end
         if (reset || steady_flow) begin
            stall_run = 0;
            rsp_stall <= 1'b0;
         end else if (stall_run > 0) begin
            stall_run--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 99) < 20) begin
            stall_run = hold_len() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      rtc = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send(ACT_READ, 3'd0, 16'h0000);
      repeat (3) send(ACT_TICK, 3'd0, 16'h0000);
      repeat (SLOTS + 1) send(ACT_ALLOC, 3'd5, 16'h0000);
      send(ACT_LOAD, 3'd0, 16'hFFFF);
      send(ACT_LOAD, 3'd7, 16'h0000);
      send(ACT_LOAD, 3'd3, 16'h0002);
      send(ACT_RELEASE, 3'd3, 16'h0000);
      send(ACT_RELEASE, 3'd3, 16'h0000);
      send(ACT_LOAD, 3'd3, 16'h0002);
      send(ACT_WRITE, SEL_COUNT_A, 16'hFFFF);
      send(ACT_WRITE, SEL_COUNT_B, 16'hFFFF);
      send(ACT_WRITE, 3'd5, 16'h1234);
      send(ACT_RSVD6, 3'd7, 16'hFFFF);
      send(ACT_RSVD7, 3'd2, 16'h5A5A);
      repeat (3) send(ACT_TICK, 3'd7, 16'hFFFF);
      send(ACT_READ, 3'd0, 16'h0000);
      req_valid <= 1'b0;

      for (int n = 0; n < NUM_SETTINGS; n++) begin
         drain();
         apply_setting(n);
         steady_flow = (n % 3 == 1);
         repeat (WORDS_PER_SETTING) send_random();
         req_valid <= 1'b0;
      end

      drain();
      repeat (4 * (SLOTS + 1)) @(posedge clock);
      if (rtc.mismatches == 0 && rtc.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/tickclk_pkg.sv
design/tickclk_cell.sv
design/tick_clock_with_countdown_timers_core.sv
tb/tick_clock_with_countdown_timers_core_tb.sv
